/* hdl/eq3_pkg.sv */
package eq3_pkg;

   localparam int StepW = 4;
   localparam int IdxW  = 3;

   localparam logic [2:0] CSR_LOW_COEFF  = 3'd0;
   localparam logic [2:0] CSR_HIGH_COEFF = 3'd1;
   localparam logic [2:0] CSR_LOW_GAIN   = 3'd2;
   localparam logic [2:0] CSR_MID_GAIN   = 3'd3;
   localparam logic [2:0] CSR_HIGH_GAIN  = 3'd4;

   localparam logic [17:0] LOW_COEFF_RST  = 18'd8214;
   localparam logic [17:0] HIGH_COEFF_RST = 18'd46046;
   localparam logic [15:0] GAIN_RST       = 16'd8192;

   // datapath operations
   localparam logic [2:0] OP_NOP  = 3'd0;
   localparam logic [2:0] OP_LOAD = 3'd1;
   localparam logic [2:0] OP_DIFF = 3'd2;
   localparam logic [2:0] OP_UPD  = 3'd3;
   localparam logic [2:0] OP_BAND = 3'd4;
   localparam logic [2:0] OP_FIN  = 3'd5;

   // multiplier operand A
   localparam logic [1:0] A_DIFF = 2'd0;
   localparam logic [1:0] A_LO   = 2'd1;
   localparam logic [1:0] A_MID  = 2'd2;
   localparam logic [1:0] A_HI   = 2'd3;

   // multiplier operand B
   localparam logic [1:0] B_COEF  = 2'd0;
   localparam logic [1:0] B_LGAIN = 2'd1;
   localparam logic [1:0] B_MGAIN = 2'd2;
   localparam logic [1:0] B_HGAIN = 2'd3;

   // accumulator operation
   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   // sequencing
   localparam logic [1:0] JC_NEXT = 2'd0;
   localparam logic [1:0] JC_HOLD = 2'd1;
   localparam logic [1:0] JC_LOOP = 2'd2;

   localparam logic [IdxW-1:0] IDX_LAST = 3'd7;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [1:0]       a_sel;
      logic [1:0]       b_sel;
      logic             mul_en;
      logic [1:0]       acc_op;
      logic [1:0]       jcond;
      logic [StepW-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic [2:0]      opcode;
      logic [1:0]      a_sel;
      logic [1:0]      b_sel;
      logic            mul_en;
      logic [1:0]      acc_op;
      logic [IdxW-1:0] idx;
      logic            fire;
   } ctrl_type;

   typedef struct packed {
      logic in_valid;
      logic out_free;
   } status_type;

   function automatic ucode_type rom_word(input logic [StepW-1:0] step);
      ucode_type w;
      w = '{OP_NOP, A_DIFF, B_COEF, 1'b0, ACC_NONE, JC_HOLD, 4'd0};
      unique case (step)
         4'd0: w = '{OP_LOAD, A_DIFF, B_COEF,  1'b0, ACC_NONE, JC_HOLD, 4'd1};
         4'd1: w = '{OP_DIFF, A_DIFF, B_COEF,  1'b0, ACC_NONE, JC_NEXT, 4'd0};
         4'd2: w = '{OP_NOP,  A_DIFF, B_COEF,  1'b1, ACC_NONE, JC_NEXT, 4'd0};
         4'd3: w = '{OP_UPD,  A_DIFF, B_COEF,  1'b0, ACC_NONE, JC_LOOP, 4'd1};
         4'd4: w = '{OP_BAND, A_DIFF, B_COEF,  1'b0, ACC_NONE, JC_NEXT, 4'd0};
         4'd5: w = '{OP_NOP,  A_LO,   B_LGAIN, 1'b1, ACC_NONE, JC_NEXT, 4'd0};
         4'd6: w = '{OP_NOP,  A_MID,  B_MGAIN, 1'b1, ACC_LOAD, JC_NEXT, 4'd0};
         4'd7: w = '{OP_NOP,  A_HI,   B_HGAIN, 1'b1, ACC_ADD,  JC_NEXT, 4'd0};
         4'd8: w = '{OP_NOP,  A_DIFF, B_COEF,  1'b0, ACC_ADD,  JC_NEXT, 4'd0};
         4'd9: w = '{OP_FIN,  A_DIFF, B_COEF,  1'b0, ACC_NONE, JC_HOLD, 4'd0};
         default: w = '{OP_NOP, A_DIFF, B_COEF, 1'b0, ACC_NONE, JC_HOLD, 4'd0};
      endcase
      return w;
   endfunction

endpackage

/* hdl/eq3_sequencer.sv */
module eq3_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  eq3_pkg::status_type status,
   output eq3_pkg::ctrl_type   ctrl
);

   logic [eq3_pkg::StepW-1:0] step_ff, step_in;
   logic [eq3_pkg::IdxW-1:0]  idx_ff, idx_in;
   eq3_pkg::ucode_type        word;
   logic                      fire;

   assign word = eq3_pkg::rom_word(step_ff);

   // a load or finish step only completes when its transaction can happen
   always_comb begin
      fire = 1'b1;
      if (word.opcode == eq3_pkg::OP_LOAD) begin
         fire = status.in_valid;
      end else if (word.opcode == eq3_pkg::OP_FIN) begin
         fire = status.out_free;
      end
   end

   always_comb begin
      step_in = step_ff + 4'd1;
      unique case (word.jcond)
         eq3_pkg::JC_HOLD: step_in = fire ? word.target : step_ff;
         eq3_pkg::JC_LOOP: if (idx_ff != eq3_pkg::IDX_LAST) begin
            step_in = word.target;
         end
         default: step_in = step_ff + 4'd1;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (word.opcode == eq3_pkg::OP_LOAD) begin
         idx_in = '0;
      end else if (word.opcode == eq3_pkg::OP_UPD) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         idx_ff  <= '0;
      end else begin
         step_ff <= step_in;
         idx_ff  <= idx_in;
      end
   end

   assign ctrl = '{word.opcode, word.a_sel, word.b_sel, word.mul_en, word.acc_op, idx_ff, fire};

endmodule

/* hdl/eq3_datapath.sv */
module eq3_datapath (
   input  logic                clock,
   input  logic                reset,
   input  eq3_pkg::ctrl_type   ctrl,
   input  logic signed [15:0]  sample_in,
   input  logic                csr_we,
   input  logic [2:0]          csr_addr,
   input  logic [17:0]         csr_wdata,
   input  logic                out_ready,
   output logic                out_valid,
   output logic signed [15:0]  sample_out,
   output logic                out_free
);

   logic [17:0] low_coeff_ff, high_coeff_ff;
   logic [15:0] low_gain_ff, mid_gain_ff, high_gain_ff;

   logic signed [31:0] pole_ff [8];
   logic signed [15:0] hist_ff [3];
   logic signed [31:0] x_ff, u_ff;
   logic signed [33:0] diff_ff, hi_ff, mid_ff;
   logic signed [52:0] prod_ff;
   logic signed [54:0] acc_ff;
   logic               out_valid_ff;
   logic signed [15:0] out_data_ff;

   logic signed [31:0] pole_rd, d_w, pole_sat;
   logic signed [33:0] a_mux, hi_w, mid_w;
   logic [17:0]        b_mux;
   logic signed [52:0] prod_w, prod_rnd;
   logic signed [37:0] pole_sum;
   logic signed [54:0] acc_rnd;
   logic signed [25:0] r_w;
   logic signed [15:0] r_sat;

   assign pole_rd = pole_ff[ctrl.idx];
   assign d_w     = {hist_ff[2], 16'h0000};
   assign hi_w    = 34'(d_w) - 34'(pole_ff[7]);
   assign mid_w   = 34'(d_w) - hi_w - 34'(pole_ff[3]);

   always_comb begin
      unique case (ctrl.a_sel)
         eq3_pkg::A_DIFF: a_mux = diff_ff;
         eq3_pkg::A_LO:   a_mux = 34'(pole_ff[3]);
         eq3_pkg::A_MID:  a_mux = mid_ff;
         default:         a_mux = hi_ff;
      endcase
      unique case (ctrl.b_sel)
         eq3_pkg::B_COEF:  b_mux = ctrl.idx[2] ? high_coeff_ff : low_coeff_ff;
         eq3_pkg::B_LGAIN: b_mux = {2'b00, low_gain_ff};
         eq3_pkg::B_MGAIN: b_mux = {2'b00, mid_gain_ff};
         default:          b_mux = {2'b00, high_gain_ff};
      endcase
   end

   assign prod_w = a_mux * $signed({1'b0, b_mux});

   // round half up, add to the pole, clamp to 32 bits
   assign prod_rnd = prod_ff + 53'sd32768;
   assign pole_sum = 38'(pole_rd) + 38'($signed(prod_rnd[52:16]));
   always_comb begin
      if (pole_sum[37:31] == 7'b0000000 || pole_sum[37:31] == 7'b1111111) begin
         pole_sat = pole_sum[31:0];
      end else if (pole_sum[37]) begin
         pole_sat = 32'sh8000_0000;
      end else begin
         pole_sat = 32'sh7fff_ffff;
      end
   end

   assign acc_rnd = acc_ff + 55'sd268435456;
   assign r_w     = acc_rnd[54:29];
   always_comb begin
      if (r_w[25:15] == 11'h000 || r_w[25:15] == 11'h7ff) begin
         r_sat = r_w[15:0];
      end else if (r_w[25]) begin
         r_sat = 16'sh8000;
      end else begin
         r_sat = 16'sh7fff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_coeff_ff  <= eq3_pkg::LOW_COEFF_RST;
         high_coeff_ff <= eq3_pkg::HIGH_COEFF_RST;
         low_gain_ff   <= eq3_pkg::GAIN_RST;
         mid_gain_ff   <= eq3_pkg::GAIN_RST;
         high_gain_ff  <= eq3_pkg::GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            eq3_pkg::CSR_LOW_COEFF:  low_coeff_ff  <= csr_wdata;
            eq3_pkg::CSR_HIGH_COEFF: high_coeff_ff <= csr_wdata;
            eq3_pkg::CSR_LOW_GAIN:   low_gain_ff   <= csr_wdata[15:0];
            eq3_pkg::CSR_MID_GAIN:   mid_gain_ff   <= csr_wdata[15:0];
            eq3_pkg::CSR_HIGH_GAIN:  high_gain_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) pole_ff[i] <= '0;
         for (int i = 0; i < 3; i++) hist_ff[i] <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ctrl.opcode == eq3_pkg::OP_UPD) begin
            pole_ff[ctrl.idx] <= pole_sat;
         end
         if (ctrl.opcode == eq3_pkg::OP_FIN && ctrl.fire) begin
            out_valid_ff <= 1'b1;
            hist_ff[2]   <= hist_ff[1];
            hist_ff[1]   <= hist_ff[0];
            hist_ff[0]   <= x_ff[31:16];
         end else if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.opcode == eq3_pkg::OP_LOAD && ctrl.fire) begin
         x_ff <= {sample_in, 16'h0000};
         u_ff <= {sample_in, 16'h0000};
      end
      if (ctrl.opcode == eq3_pkg::OP_DIFF) begin
         diff_ff <= 34'(u_ff) - 34'(pole_rd);
      end
      // the next stage takes this pole; the high cascade restarts from the sample
      if (ctrl.opcode == eq3_pkg::OP_UPD) begin
         u_ff <= (ctrl.idx[1:0] == 2'b11) ? x_ff : pole_sat;
      end
      if (ctrl.opcode == eq3_pkg::OP_BAND) begin
         hi_ff  <= hi_w;
         mid_ff <= mid_w;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_w;
      end
      if (ctrl.acc_op == eq3_pkg::ACC_LOAD) begin
         acc_ff <= 55'(prod_ff);
      end else if (ctrl.acc_op == eq3_pkg::ACC_ADD) begin
         acc_ff <= acc_ff + 55'(prod_ff);
      end
      if (ctrl.opcode == eq3_pkg::OP_FIN && ctrl.fire) begin
         out_data_ff <= r_sat;
      end
   end

   assign out_valid  = out_valid_ff;
   assign sample_out = out_data_ff;
   assign out_free   = !out_valid_ff || out_ready;

endmodule

/* hdl/three_band_equalizer.sv */
// The microprogram takes one sample at a time, in its load step, then runs eight
// pole updates of three steps each on the one shared multiplier, then six band
// steps, and returns to the load step once the finish step completes.
// A result waiting in the output register holds the finish step only.
// Reset (synchronous, active high) clears poles, history and output valid and
// loads the default coefficients and gains.
module three_band_equalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] sample_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] sample_out
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [17:0] csr_wdata
);

   eq3_pkg::ctrl_type   ctrl;
   eq3_pkg::status_type status;
   logic                out_free;
   logic signed [15:0]  sample_out;

   assign status = '{req_tvalid, out_free};

   eq3_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   eq3_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample_in  ($signed(req_tdata)),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .sample_out (sample_out),
      .out_free   (out_free)
   );

   assign req_tready = (ctrl.opcode == eq3_pkg::OP_LOAD) && !reset;
   assign rsp_tdata  = sample_out;

endmodule

/* hdl/eq3_checker.sv */
module eq3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // no second sample right after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a sample is in flight");

   // a new result returns the sequencer to its load step
   a_ready_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("input not ready after result was produced");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind three_band_equalizer eq3_checker u_eq3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
